// ===== rtl/set_assoc_lru_cache_sim_macros.svh =====
// assertion helpers for the cache tag store checker
`ifndef SET_ASSOC_LRU_CACHE_SIM_MACROS_SVH
`define SET_ASSOC_LRU_CACHE_SIM_MACROS_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define SACL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define SACL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/sacl_pkg.sv =====
package sacl_pkg;

  // default sizing
  localparam int unsigned SACL_MAX_SET_BITS = 8;
  localparam int unsigned SACL_MAX_WAYS     = 8;
  localparam int unsigned SACL_AGE_BITS     = 32;

  // fixed field widths
  localparam int unsigned TAG_W   = 64;
  localparam int unsigned TOTAL_W = 32;

  // access codes
  typedef enum logic [1:0] {
    FUNC_LOAD   = 2'd0,
    FUNC_STORE  = 2'd1,
    FUNC_MODIFY = 2'd2,
    FUNC_FETCH  = 2'd3
  } func_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_SET_BITS    = 2'd0,
    CFG_OFFSET_BITS = 2'd1,
    CFG_WAYS        = 2'd2,
    CFG_UNUSED      = 2'd3
  } cfg_idx_e;

  // per-way result of the compare/age unit
  typedef struct packed {
    logic hit;   // valid line with matching tag
    logic take;  // becomes the current victim candidate
    logic free;  // line is invalid
  } sacl_scan_t;

endpackage

// ===== rtl/sacl_ram.sv =====
module sacl_ram import sacl_pkg::*; #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/sacl_way_unit.sv =====
module sacl_way_unit import sacl_pkg::*; #(
  parameter int unsigned AGE_BITS = SACL_AGE_BITS
) (
  input  logic                valid_i,
  input  logic [TAG_W-1:0]    line_tag_i,
  input  logic [AGE_BITS-1:0] age_i,
  input  logic [TAG_W-1:0]    look_tag_i,
  input  logic [AGE_BITS-1:0] best_age_i,
  input  logic                free_found_i,
  output logic [AGE_BITS-1:0] new_age_o,
  output sacl_scan_t          scan_o
);

  logic match;

  assign match = valid_i && (line_tag_i == look_tag_i);

  // hit clears the age, other valid lines age with saturation
  always_comb begin
    if (match) begin
      new_age_o = '0;
    end else if (valid_i && (age_i != {AGE_BITS{1'b1}})) begin
      new_age_o = age_i + AGE_BITS'(1);
    end else begin
      new_age_o = age_i;
    end
  end

  assign scan_o.hit  = match;
  assign scan_o.free = !valid_i;
  assign scan_o.take = !free_found_i && (!valid_i || (new_age_o > best_age_i));

endmodule

// ===== rtl/set_assoc_lru_cache_sim.sv =====
// set-associative cache tag store with age-counter lru replacement
//
// access channel: an item (func_i, address_i) is taken at a rising edge with start
// high and busy low. loads and stores give one lookup result, modify gives two
// (the second with last_o set), instruction fetch gives none and leaves busy low.
// each result shows on the result ports for one cycle under result_valid_o; the
// receiver cannot stall, so nothing waits on it.
// config channel: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i; ready is
// always high, writes belong in idle time. index 0 set bits, 1 offset bits, 2 ways.
// sequence: a lookup runs from accept to result strobe through address split,
// first read of the line store, one way at a time through the shared compare/age
// unit (read of way w+1 overlaps the write-back of way w), then the fill step.
// a modify repeats it from the line store read on. busy drops the cycle its last result shows.
// the line store is a single ram with one read and one write port; that port pair
// sets the one-way-per-cycle pace.
// reset: counters and config return to reset values, then a clearing pass writes
// every line entry, 2^MAX_SET_BITS*MAX_WAYS of them (2048 at defaults), with busy high;
// config writes are taken during the pass.
module set_assoc_lru_cache_sim import sacl_pkg::*; #(
  parameter int unsigned MAX_SET_BITS = SACL_MAX_SET_BITS,
  parameter int unsigned MAX_WAYS     = SACL_MAX_WAYS,
  parameter int unsigned AGE_BITS     = SACL_AGE_BITS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // access channel
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         func_i,
  input  logic [63:0]        address_i,
  // config channel
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [5:0]         cfg_data_i,
  // result channel
  output logic               result_valid_o,
  output logic               hit_o,
  output logic               evicted_o,
  output logic               last_o,
  output logic [TOTAL_W-1:0] hit_total_o,
  output logic [TOTAL_W-1:0] miss_total_o,
  output logic [TOTAL_W-1:0] eviction_total_o
);

  localparam int unsigned DEPTH   = (2 ** MAX_SET_BITS) * MAX_WAYS;
  localparam int unsigned ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned SET_W   = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int unsigned WAY_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int unsigned NW_W    = $clog2(MAX_WAYS + 1);
  localparam int unsigned ENTRY_W = 1 + TAG_W + AGE_BITS;

  // sequencer states
  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_CLEAR = 6'b000010,
    ST_SETUP = 6'b000100,
    ST_PRIME = 6'b001000,
    ST_SCAN  = 6'b010000,
    ST_DONE  = 6'b100000
  } state_e;

  function automatic logic [TOTAL_W-1:0] sat_inc(input logic [TOTAL_W-1:0] v);
    sat_inc = (v == {TOTAL_W{1'b1}}) ? v : v + TOTAL_W'(1);
  endfunction

  state_e state_q, state_d;

  // config registers
  logic [3:0] set_bits_q;
  logic [5:0] offset_bits_q;
  logic [3:0] ways_q;

  // captured item and split address
  logic [63:0]       addr_q;
  logic              mod_pend_q;
  logic [TAG_W-1:0]  tag_q;
  logic [ADDR_W-1:0] base_q;
  logic [NW_W-1:0]   nw_q;

  // scan state
  logic [WAY_W-1:0]    way_q;
  logic [WAY_W-1:0]    victim_q;
  logic [AGE_BITS-1:0] best_q;
  logic                hit_q;
  logic                free_q;
  logic [ADDR_W-1:0]   clr_q;

  // totals
  logic [TOTAL_W-1:0] hit_sum_q;
  logic [TOTAL_W-1:0] miss_sum_q;
  logic [TOTAL_W-1:0] evict_sum_q;

  // result registers
  logic               res_valid_q;
  logic               res_hit_q;
  logic               res_evict_q;
  logic               res_last_q;
  logic [TOTAL_W-1:0] res_hits_q;
  logic [TOTAL_W-1:0] res_misses_q;
  logic [TOTAL_W-1:0] res_evicts_q;

  // line store port signals
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;

  // address split
  logic [3:0]        sb;
  logic [6:0]        tshift;
  logic [SET_W-1:0]  set_idx;
  logic [TAG_W-1:0]  tag_calc;
  logic [NW_W-1:0]   nw_calc;
  logic [63:0]       addr_sh_set;

  // shared unit
  logic [AGE_BITS-1:0] new_age;
  sacl_scan_t          scan;
  logic                last_way;

  logic accept;

  assign busy        = (state_q != ST_IDLE);
  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;

  // effective set bits and way count after clamping
  assign sb = ({1'b0, set_bits_q} > 5'(MAX_SET_BITS)) ? 4'(MAX_SET_BITS) : set_bits_q;

  always_comb begin
    if (ways_q == 4'd0) begin
      nw_calc = NW_W'(1);
    end else if ({2'b00, ways_q} > 6'(MAX_WAYS)) begin
      nw_calc = NW_W'(MAX_WAYS);
    end else begin
      nw_calc = NW_W'(ways_q);
    end
  end

  assign tshift      = {3'b000, sb} + {1'b0, offset_bits_q};
  assign addr_sh_set = addr_q >> offset_bits_q;
  assign set_idx     = addr_sh_set[SET_W-1:0] & ~({SET_W{1'b1}} << sb);
  // tag is zero once the shift reaches the word width
  assign tag_calc    = tshift[6] ? '0 : (addr_q >> tshift[5:0]);

  assign last_way = ((NW_W'(way_q) + NW_W'(1)) == nw_q);

  sacl_way_unit #(
    .AGE_BITS (AGE_BITS)
  ) u_way (
    .valid_i      (ram_rdata[ENTRY_W-1]),
    .line_tag_i   (ram_rdata[AGE_BITS +: TAG_W]),
    .age_i        (ram_rdata[AGE_BITS-1:0]),
    .look_tag_i   (tag_q),
    .best_age_i   (best_q),
    .free_found_i (free_q),
    .new_age_o    (new_age),
    .scan_o       (scan)
  );

  sacl_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_lines (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // line store access per state
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = base_q + ADDR_W'(way_q);
    ram_wdata = {ram_rdata[ENTRY_W-1], ram_rdata[AGE_BITS +: TAG_W], new_age};
    ram_raddr = base_q + ADDR_W'(way_q) + ADDR_W'(1);
    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
      end
      ST_PRIME: begin
        ram_raddr = base_q;
      end
      ST_SCAN: begin
        // write back way w while way w+1 is read
        ram_we = 1'b1;
      end
      ST_DONE: begin
        // fill on a miss: valid, new tag, age zero
        ram_we    = !hit_q;
        ram_waddr = base_q + ADDR_W'(victim_q);
        ram_wdata = {1'b1, tag_q, {AGE_BITS{1'b0}}};
      end
      default: begin
      end
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_q == ADDR_W'(DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept && (func_e'(func_i) != FUNC_FETCH)) begin
          state_d = ST_SETUP;
        end
      end
      ST_SETUP: state_d = ST_PRIME;
      ST_PRIME: state_d = ST_SCAN;
      ST_SCAN: begin
        if (last_way) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: state_d = mod_pend_q ? ST_PRIME : ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_CLEAR;
      clr_q         <= '0;
      set_bits_q    <= 4'd4;
      offset_bits_q <= 6'd4;
      ways_q        <= 4'd1;
      mod_pend_q    <= 1'b0;
      hit_sum_q     <= '0;
      miss_sum_q    <= '0;
      evict_sum_q   <= '0;
      res_valid_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= 1'b0;

      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + ADDR_W'(1);
      end

      if (cfg_valid_i) begin
        unique case (cfg_idx_e'(cfg_index_i))
          CFG_SET_BITS:    set_bits_q    <= cfg_data_i[3:0];
          CFG_OFFSET_BITS: offset_bits_q <= cfg_data_i;
          CFG_WAYS:        ways_q        <= cfg_data_i[3:0];
          CFG_UNUSED:      ;
          default:         ;
        endcase
      end

      if (accept) begin
        mod_pend_q <= (func_e'(func_i) == FUNC_MODIFY);
      end

      if (state_q == ST_DONE) begin
        res_valid_q <= 1'b1;
        mod_pend_q  <= 1'b0;
        if (hit_q) begin
          hit_sum_q <= sat_inc(hit_sum_q);
        end else begin
          miss_sum_q <= sat_inc(miss_sum_q);
          if (!free_q) begin
            evict_sum_q <= sat_inc(evict_sum_q);
          end
        end
      end
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      addr_q <= address_i;
    end

    if (state_q == ST_SETUP) begin
      tag_q  <= tag_calc;
      base_q <= ADDR_W'(set_idx) * ADDR_W'(MAX_WAYS);
      nw_q   <= nw_calc;
    end

    if (state_q == ST_PRIME) begin
      way_q    <= '0;
      victim_q <= '0;
      best_q   <= '0;
      hit_q    <= 1'b0;
      free_q   <= 1'b0;
    end

    if (state_q == ST_SCAN) begin
      way_q <= way_q + WAY_W'(1);
      if (scan.hit) begin
        hit_q <= 1'b1;
      end
      // first invalid way wins, else strictly greater age
      if (scan.take) begin
        victim_q <= way_q;
        if (scan.free) begin
          free_q <= 1'b1;
        end else begin
          best_q <= new_age;
        end
      end
    end

    if (state_q == ST_DONE) begin
      res_hit_q    <= hit_q;
      res_evict_q  <= !hit_q && !free_q;
      res_last_q   <= !mod_pend_q;
      res_hits_q   <= hit_q ? sat_inc(hit_sum_q) : hit_sum_q;
      res_misses_q <= hit_q ? miss_sum_q : sat_inc(miss_sum_q);
      res_evicts_q <= (!hit_q && !free_q) ? sat_inc(evict_sum_q) : evict_sum_q;
    end
  end

  assign result_valid_o   = res_valid_q;
  assign hit_o            = res_hit_q;
  assign evicted_o        = res_evict_q;
  assign last_o           = res_last_q;
  assign hit_total_o      = res_hits_q;
  assign miss_total_o     = res_misses_q;
  assign eviction_total_o = res_evicts_q;

endmodule

// ===== rtl/sacl_checker.sv =====
`include "set_assoc_lru_cache_sim_macros.svh"

module sacl_checker import sacl_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input logic [1:0]         func_i,
  input logic               result_valid_o,
  input logic               hit_o,
  input logic               evicted_o,
  input logic               last_o,
  input logic [TOTAL_W-1:0] eviction_total_o
);

  // a hit never replaces a line
  `SACL_ASSERT_IMP(a_hit_no_evict, result_valid_o, !(hit_o && evicted_o), "hit with eviction")

  // a reported eviction is in the running count
  `SACL_ASSERT_IMP(a_evict_counted, result_valid_o && evicted_o, eviction_total_o != '0, "eviction not counted")

  // first result of a modify keeps the block busy for the second lookup
  `SACL_ASSERT_IMP(a_modify_pending, result_valid_o && !last_o, busy, "idle between modify lookups")

  // strobes never sit back to back: another result needs prime, scan and done again
  `SACL_ASSERT_NXT(a_strobe_single, result_valid_o, !result_valid_o, "result strobe too long")

  // a data access keeps the block busy while it is looked up
  `SACL_ASSERT_NXT(a_access_busy, start && !busy && (func_i != FUNC_FETCH), busy, "access not started")

endmodule

bind set_assoc_lru_cache_sim sacl_checker u_sacl_checker (.*);
